[src/sfd_pkg.sv]
package sfd_pkg;

   // Framing bytes.
   localparam logic [7:0] SYNC_BYTE = 8'hBE;
   localparam logic [7:0] END_BYTE  = 8'h27;
   localparam logic [7:0] SUM_START = 8'h00;

   // Result kinds.
   localparam logic KIND_PAYLOAD = 1'b0;
   localparam logic KIND_END     = 1'b1;

   // Frame status codes reported in an end or error result.
   localparam logic [2:0] ST_GOOD     = 3'd0;
   localparam logic [2:0] ST_LENCOPY  = 3'd1;
   localparam logic [2:0] ST_SYNC2    = 3'd2;
   localparam logic [2:0] ST_ENDMARK  = 3'd3;
   localparam logic [2:0] ST_CHECKSUM = 3'd4;

   // One result item as it travels from the parser to the output buffer.
   typedef struct packed {
      logic       kind;
      logic [7:0] data;
      logic [7:0] index;
      logic [2:0] status;
      logic [7:0] length;
   } result_type;

endpackage

[src/sfd_parse.sv]
module sfd_parse
   import sfd_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       in_take,
   input  logic [7:0] rx_byte,
   output logic       res_valid,
   output result_type res
);

   typedef enum logic [2:0] {
      PH_HUNT,
      PH_LEN,
      PH_LENCOPY,
      PH_SYNC2,
      PH_PAYLOAD,
      PH_CHECKSUM,
      PH_END
   } phase_type;

   phase_type  phase_ff, phase_in;
   logic [7:0] length_ff, length_in;
   logic [7:0] count_ff, count_in;
   logic [7:0] sum_ff, sum_in;
   logic       match_ff, match_in;
   logic [7:0] count_next;

   assign count_next = count_ff + 8'd1;

   // Next frame state and the result caused by the byte being taken.
   always_comb begin
      phase_in  = phase_ff;
      length_in = length_ff;
      count_in  = count_ff;
      sum_in    = sum_ff;
      match_in  = match_ff;
      res_valid = 1'b0;
      res       = '0;
      case (phase_ff)
         PH_HUNT: begin
            if (rx_byte == SYNC_BYTE) begin
               phase_in = PH_LEN;
            end
         end
         PH_LEN: begin
            length_in = rx_byte;
            phase_in  = PH_LENCOPY;
         end
         PH_LENCOPY: begin
            if (rx_byte != length_ff) begin
               res_valid  = 1'b1;
               res.kind   = KIND_END;
               res.status = ST_LENCOPY;
               res.length = length_ff;
               phase_in   = PH_HUNT;
            end else begin
               phase_in = PH_SYNC2;
            end
         end
         PH_SYNC2: begin
            if (rx_byte != SYNC_BYTE) begin
               res_valid  = 1'b1;
               res.kind   = KIND_END;
               res.status = ST_SYNC2;
               res.length = length_ff;
               phase_in   = PH_HUNT;
            end else begin
               sum_in   = SUM_START;
               count_in = '0;
               phase_in = (length_ff == 8'd0) ? PH_CHECKSUM : PH_PAYLOAD;
            end
         end
         PH_PAYLOAD: begin
            res_valid = 1'b1;
            res.kind  = KIND_PAYLOAD;
            res.data  = rx_byte;
            res.index = count_ff;
            sum_in    = sum_ff + rx_byte;
            count_in  = count_next;
            if (count_next == length_ff) begin
               phase_in = PH_CHECKSUM;
            end
         end
         PH_CHECKSUM: begin
            match_in = (rx_byte == sum_ff);
            phase_in = PH_END;
         end
         PH_END: begin
            res_valid  = 1'b1;
            res.kind   = KIND_END;
            res.length = length_ff;
            if (rx_byte != END_BYTE) begin
               res.status = ST_ENDMARK;
            end else if (!match_ff) begin
               res.status = ST_CHECKSUM;
            end else begin
               res.status = ST_GOOD;
            end
            phase_in = PH_HUNT;
         end
         default: begin
            phase_in = PH_HUNT;
         end
      endcase
   end

   // Frame state advances only when a byte transaction is taken.
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= PH_HUNT;
         length_ff <= '0;
         count_ff  <= '0;
         sum_ff    <= '0;
         match_ff  <= 1'b0;
      end else if (in_take) begin
         phase_ff  <= phase_in;
         length_ff <= length_in;
         count_ff  <= count_in;
         sum_ff    <= sum_in;
         match_ff  <= match_in;
      end
   end

   // While payload is expected, fewer bytes than declared have arrived.
   assert property (@(posedge clock) disable iff (reset)
      phase_ff == PH_PAYLOAD |-> count_ff < length_ff)
      else $error("payload count reached declared length in payload phase");

   // An end or error result always sends the parser back to hunting.
   assert property (@(posedge clock) disable iff (reset)
      in_take && res_valid && res.kind == KIND_END |=> phase_ff == PH_HUNT)
      else $error("parser did not return to hunt after frame end");

   // A payload result carries no status and no length.
   assert property (@(posedge clock) disable iff (reset)
      res_valid && res.kind == KIND_PAYLOAD |-> res.status == ST_GOOD && res.length == 8'd0)
      else $error("payload result carries end fields");

endmodule

[src/sfd_out_buf.sv]
module sfd_out_buf
   import sfd_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       in_valid,
   output logic       in_ready,
   input  result_type in_data,
   output logic       out_valid,
   input  logic       out_ready,
   output result_type out_data
);

   logic       out_valid_ff;
   logic       skid_valid_ff;
   result_type out_data_ff;
   result_type skid_data_ff;
   logic       take;

   // The skid stage holds one result that arrived while the output stalled.
   assign in_ready  = !skid_valid_ff;
   assign take      = in_valid && in_ready;
   assign out_valid = out_valid_ff;
   assign out_data  = out_data_ff;

   // Control flags of the output and skid registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (!out_valid_ff || out_ready) begin
         out_valid_ff  <= skid_valid_ff || take;
         skid_valid_ff <= 1'b0;
      end else if (take) begin
         skid_valid_ff <= 1'b1;
      end
   end

   // Result payload registers.
   always_ff @(posedge clock) begin
      if (!out_valid_ff || out_ready) begin
         out_data_ff <= skid_valid_ff ? skid_data_ff : in_data;
      end else if (take) begin
         skid_data_ff <= in_data;
      end
   end

   // The skid stage is only ever filled behind a waiting output.
   assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> out_valid_ff)
      else $error("skid holds a result while output is empty");

   // A stalled output that takes a new result must park it in the skid.
   assert property (@(posedge clock) disable iff (reset)
      take && out_valid_ff && !out_ready |=> skid_valid_ff)
      else $error("result lost while output stalled");

   // Draining the skid moves its result to the output.
   assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff && out_ready |=> out_valid_ff && !skid_valid_ff)
      else $error("skid result not moved to output");

endmodule

[src/serial_frame_deframer_sum_check_unit.sv]
// Serial frame deframer with additive checksum. Received bytes enter on the
// req_ channel one per transaction; frames are sync 0xBE, length, length copy,
// sync 0xBE, payload, checksum (payload sum mod 256) and end marker 0x27.
// Each payload byte produces a payload result at once (tuser 0), and each frame
// end or header error produces one status result (tuser 1) carrying the status
// and the declared length. Bytes outside a frame that are not 0xBE are dropped,
// and a byte that breaks the header is not rechecked as a new sync. The block
// takes one byte every clock cycle while req_tready is high. The parser's
// frame state registers update by a compare and an 8-bit add, and a two-entry
// output buffer (output register plus skid) lets req_tready stay high until
// two results wait behind a stalled rsp_ side.
module serial_frame_deframer_sum_check_unit
   import sfd_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] rx_byte
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,   // [7:0] out_data, [15:8] out_index,
                                    // [18:16] frame_status, [26:19] frame_length
   output logic        rsp_tuser    // [0] out_kind
);

   logic       in_take;
   logic       res_valid;
   result_type res;
   result_type rsp_res;

   assign in_take = req_tvalid && req_tready;

   // Frame parser.
   sfd_parse u_parse (
      .clock     (clock),
      .reset     (reset),
      .in_take   (in_take),
      .rx_byte   (req_tdata),
      .res_valid (res_valid),
      .res       (res)
   );

   // Output register with skid stage.
   sfd_out_buf u_out_buf (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (in_take && res_valid),
      .in_ready  (req_tready),
      .in_data   (res),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_data  (rsp_res)
   );

   // Pack the result fields onto the stream bus.
   assign rsp_tuser = rsp_res.kind;
   assign rsp_tdata = {5'd0, rsp_res.length, rsp_res.status, rsp_res.index, rsp_res.data};

endmodule
